FILE: hw/rtl/ffla_pkg.sv
// Package for the frame free-list allocator: transaction structs, command
// and status codes, and the controller/datapath interface types.
// No dependencies.
`default_nettype none

package ffla_pkg;

    // Fixed field widths
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 5;
    localparam int FREE_W = 11;
    localparam int ST_W   = 2;

    // Command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_RET = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    // Input transaction
    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] frame_count;
        logic [IDX_W-1:0] frame_index;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [IDX_W-1:0]  granted_index;
        logic [ST_W-1:0]   status;
        logic              last;
        logic [FREE_W-1:0] free_count;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the input transaction
        logic single;     // emit the one result of a return or failed get
        logic pop_first;  // first stack read of a get, loads the pop count
        logic pop_rd;     // read the top of stack and pop it
        logic pop_emit;   // emit the popped frame
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic get_ok;     // latched get can be served
        logic out_free;   // output register can take a result this cycle
        logic last_pop;   // the pending pop result is the final one
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/frame_free_list_allocator_unit.sv
// Top level of the frame free-list allocator: controller plus datapath.
// Depends on ffla_pkg, ffla_ctrl and ffla_dpath.
`default_nettype none

// LIFO allocator of frame indices. After reset every frame is free with the
// highest index on top; reset takes effect at once (a low-water mark tracks
// which stack entries still hold their reset value, so there is no clearing
// pass). One transaction is handled at a time. A return, or a get that fails,
// is accepted, evaluated and emitted once the output register is free. A get
// of n frames is accepted, evaluated and then popped: the stack memory's single
// registered read port pops one frame per cycle, and each pop waits on a free
// output register. Get results come out in pop order, the final one flagged by last.
module frame_free_list_allocator_unit #(
    parameter int FRAMES    = 1024,
    parameter int MAX_GRANT = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  ffla_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  wire                 i_stall,
    output ffla_pkg::t_out_item o_result
);

    ffla_pkg::t_dp_cmd  dp_cmd;
    ffla_pkg::t_dp_stat dp_stat;

    // Sequencer
    ffla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (dp_stat),
        .o_stall (o_stall),
        .o_cmd   (dp_cmd)
    );

    // Stack and output register
    ffla_dpath #(
        .FRAMES    (FRAMES),
        .MAX_GRANT (MAX_GRANT)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .i_stall  (i_stall),
        .o_stat   (dp_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/ffla_dpath.sv
// Datapath of the frame free-list allocator: stack memory, top pointer,
// low-water mark, pop counter and the output register.
// Depends on ffla_pkg.
`default_nettype none

module ffla_dpath #(
    parameter int FRAMES    = 1024,
    parameter int MAX_GRANT = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ffla_pkg::t_in_item  i_item,
    input  ffla_pkg::t_dp_cmd   i_cmd,
    input  wire                 i_stall,
    output ffla_pkg::t_dp_stat  o_stat,
    output logic                o_valid,
    output ffla_pkg::t_out_item o_result
);

    localparam int TOP_W  = $clog2(FRAMES + 1);
    localparam int ADDR_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // Stack storage, entries below the low-water mark were never written
    logic [ffla_pkg::IDX_W-1:0] r_mem [FRAMES];

    // Latched transaction
    logic                        r_cmd;
    logic [ffla_pkg::CNT_W-1:0]  r_count;
    logic [ffla_pkg::IDX_W-1:0]  r_index;

    // Stack pointers and pop bookkeeping
    logic [TOP_W-1:0]            r_top, n_top;
    logic [TOP_W-1:0]            r_low, n_low;
    logic [ffla_pkg::CNT_W-1:0]  r_remain, n_remain;
    logic [ADDR_W-1:0]           r_rd_addr;
    logic                        r_rd_orig;
    logic [ffla_pkg::IDX_W-1:0]  r_mem_q;

    // Output register
    logic                        r_out_valid, n_out_valid;
    ffla_pkg::t_out_item         r_out, n_out;

    logic                        full;
    logic                        count_zero;
    logic                        count_short;
    logic                        do_push;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        rd_orig;
    logic [ffla_pkg::ST_W-1:0]   single_st;
    logic [31:0]                 rd_addr32;
    logic [31:0]                 free32;

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_item.cmd;
            r_count <= i_item.frame_count;
            r_index <= i_item.frame_index;
        end
    end

    // Request checks
    assign full        = (r_top == TOP_W'(FRAMES));
    assign count_zero  = (r_count == '0);
    assign count_short = (32'(r_count) > 32'(MAX_GRANT)) || (32'(r_count) > 32'(r_top));
    assign do_push     = i_cmd.single && (r_cmd == ffla_pkg::CMD_RET) && !full;

    // Next top of stack address and whether it still holds its reset value
    assign rd_addr = ADDR_W'(r_top - TOP_W'(1));
    assign rd_orig = (TOP_W'(rd_addr) < r_low);

    always_comb begin
        if (r_cmd == ffla_pkg::CMD_RET) begin
            single_st = full ? ffla_pkg::ST_FULL : ffla_pkg::ST_OK;
        end else begin
            single_st = count_zero ? ffla_pkg::ST_ZERO : ffla_pkg::ST_SHORT;
        end
    end

    // Stack memory: one write port for returns, one registered read for pops
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_top[ADDR_W-1:0]] <= r_index;
        end
        if (i_cmd.pop_rd) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // Pointer and counter updates
    always_comb begin
        n_top    = r_top;
        n_low    = r_low;
        n_remain = r_remain;
        if (do_push) begin
            n_top = r_top + TOP_W'(1);
        end
        if (i_cmd.pop_rd) begin
            n_top = r_top - TOP_W'(1);
            if (rd_orig) begin
                n_low = TOP_W'(rd_addr);
            end
        end
        if (i_cmd.pop_first) begin
            n_remain = r_count;
        end else if (i_cmd.pop_emit) begin
            n_remain = r_remain - ffla_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_rd) begin
            r_rd_addr <= rd_addr;
            r_rd_orig <= rd_orig;
        end
    end

    // Output register load
    assign rd_addr32 = 32'(r_rd_addr);
    assign free32    = 32'(n_top);

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        if (i_cmd.single) begin
            n_out.granted_index = '0;
            n_out.status        = single_st;
            n_out.last          = 1'b1;
            n_out.free_count    = free32[ffla_pkg::FREE_W-1:0];
            n_out_valid         = 1'b1;
        end else if (i_cmd.pop_emit) begin
            n_out.granted_index = r_rd_orig ? rd_addr32[ffla_pkg::IDX_W-1:0] : r_mem_q;
            n_out.status        = ffla_pkg::ST_OK;
            n_out.last          = (r_remain == ffla_pkg::CNT_W'(1));
            n_out.free_count    = ffla_pkg::FREE_W'(32'(r_top));
            n_out_valid         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= TOP_W'(FRAMES);
            r_low       <= TOP_W'(FRAMES);
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_top       <= n_top;
            r_low       <= n_low;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Status to the controller
    assign o_stat.get_ok   = (r_cmd == ffla_pkg::CMD_GET) && !count_zero && !count_short;
    assign o_stat.out_free = !r_out_valid || !i_stall;
    assign o_stat.last_pop = (r_remain == ffla_pkg::CNT_W'(1));

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

FILE: hw/rtl/ffla_ctrl.sv
// Controller of the frame free-list allocator: sequences accept, evaluate
// and the per-frame pop loop. Depends on ffla_pkg.
`default_nettype none

module ffla_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  ffla_pkg::t_dp_stat i_stat,
    output logic               o_stall,
    output ffla_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0] r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.get_ok) begin
                    o_cmd.pop_first = 1'b1;
                    o_cmd.pop_rd    = 1'b1;
                    n_state         = S_POP;
                end else if (i_stat.out_free) begin
                    o_cmd.single = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_emit = 1'b1;
                    if (i_stat.last_pop) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire
